>>> rtl/zfe_pkg.sv
// Shared beat types and field widths for the Z-function engine.
package zfe_pkg;

  localparam int unsigned CharW = 8;
  localparam int unsigned PosW  = 6;
  localparam int unsigned LenW  = 7;

  typedef struct packed {
    logic [CharW-1:0] char_in;
    logic             last_char;
  } zfe_in_t;

  typedef struct packed {
    logic [PosW-1:0] position;
    logic [LenW-1:0] match_length;
    logic            final_res;
    logic            overflow;
  } zfe_out_t;

endpackage

>>> rtl/zfe_char_mem.sv
// Character store: one write port and two synchronous read ports.
module zfe_char_mem #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = 6
) (
  input  logic                  clk_i,
  input  logic                  we_i,
  input  logic [AW-1:0]         waddr_i,
  input  logic [zfe_pkg::CharW-1:0] wdata_i,
  input  logic [AW-1:0]         raddr_a_i,
  input  logic [AW-1:0]         raddr_b_i,
  output logic [zfe_pkg::CharW-1:0] rdata_a_o,
  output logic [zfe_pkg::CharW-1:0] rdata_b_o
);
  import zfe_pkg::*;

  logic [CharW-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem[raddr_a_i];
    rdata_b_o <= mem[raddr_b_i];
  end

endmodule

>>> rtl/zfe_z_mem.sv
// Z-value store: one write port and one synchronous read port with enable.
module zfe_z_mem #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = 6,
  parameter int unsigned DW    = 7
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

>>> rtl/z_function_engine.sv
// Loading takes a character beat while start is high; busy stays low while loading.
// After the last character the Z pass visits each position in turn, doing one compare per
// matching character; matching compares total at most n over the whole pass.
// Emission gives one result per cycle, the first in the cycle after it starts; results
// cannot be stalled. Reset clears the control state only; both stores keep their contents.
module z_function_engine #(
  parameter int unsigned MAX_LEN = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  input  zfe_pkg::zfe_in_t  in_i,
  output logic              busy,
  output logic              res_strobe_o,
  output zfe_pkg::zfe_out_t res_o
);
  import zfe_pkg::*;

  localparam int unsigned AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int unsigned CW = $clog2(MAX_LEN + 1);

  typedef enum logic [2:0] {
    S_IDLE, S_CHECK, S_PREV, S_EXT, S_CMP, S_EMIT
  } state_e;

  state_e        state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          drop_q, drop_d;
  logic [CW-1:0] n_q, n_d;
  logic [AW-1:0] k_q, k_d;
  logic [CW-1:0] len_q, len_d;
  logic [AW-1:0] wl_q, wl_d;
  logic [CW-1:0] wr_q, wr_d;
  logic [AW-1:0] e_q, e_d;
  logic          out_vld_q, out_vld_d;
  logic [AW-1:0] out_pos_q, out_pos_d;
  logic          out_last_q, out_last_d;
  logic          out_ovf_q, out_ovf_d;

  logic             c_we;
  logic [AW-1:0]    c_waddr, c_raddr_a, c_raddr_b;
  logic [CharW-1:0] c_rdata_a, c_rdata_b;
  logic             z_we, z_re;
  logic [AW-1:0]    z_waddr, z_raddr;
  logic [CW-1:0]    z_wdata, z_rdata;

  logic [CW-1:0] k_ext, k_next, kl, kl1, len1, room, z_val;
  logic          adv, win_upd, stored;

  assign k_ext  = CW'(k_q);
  assign k_next = k_ext + CW'(1);
  assign kl     = k_ext + len_q;
  assign kl1    = kl + CW'(1);
  assign len1   = len_q + CW'(1);
  assign room   = wr_q - k_ext;
  assign stored = (cnt_q != CW'(MAX_LEN));

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    drop_d     = drop_q;
    n_d        = n_q;
    k_d        = k_q;
    len_d      = len_q;
    wl_d       = wl_q;
    wr_d       = wr_q;
    e_d        = e_q;
    out_vld_d  = 1'b0;
    out_pos_d  = out_pos_q;
    out_last_d = out_last_q;
    out_ovf_d  = out_ovf_q;
    c_we       = 1'b0;
    c_waddr    = cnt_q[AW-1:0];
    c_raddr_a  = kl[AW-1:0];
    c_raddr_b  = len_q[AW-1:0];
    z_we       = 1'b0;
    z_re       = 1'b0;
    z_waddr    = k_q;
    z_wdata    = len_q;
    z_raddr    = k_q - wl_q;
    adv        = 1'b0;
    win_upd    = 1'b0;
    z_val      = len_q;

    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          if (stored) begin
            c_we  = 1'b1;
            cnt_d = cnt_q + CW'(1);
          end else begin
            drop_d = 1'b1;
          end
          if (in_i.last_char) begin
            n_d = stored ? cnt_q + CW'(1) : cnt_q;
            // Position 0 always reports zero.
            z_we    = 1'b1;
            z_waddr = '0;
            z_wdata = '0;
            k_d     = AW'(1);
            wl_d    = '0;
            wr_d    = '0;
            e_d     = '0;
            state_d = (n_d == CW'(1)) ? S_EMIT : S_CHECK;
          end
        end
      end
      S_CHECK: begin
        if (k_ext < wr_q) begin
          z_re    = 1'b1;
          state_d = S_PREV;
        end else begin
          len_d   = '0;
          state_d = S_EXT;
        end
      end
      S_PREV: begin
        if (z_rdata < room) begin
          adv   = 1'b1;
          z_val = z_rdata;
        end else begin
          len_d   = room;
          state_d = S_EXT;
        end
      end
      S_EXT: begin
        if (kl < n_q) begin
          state_d = S_CMP;
        end else begin
          adv     = 1'b1;
          win_upd = 1'b1;
        end
      end
      S_CMP: begin
        if (c_rdata_a == c_rdata_b) begin
          if (kl1 < n_q) begin
            // Issue the next compare pair while this one retires.
            c_raddr_a = kl1[AW-1:0];
            c_raddr_b = len1[AW-1:0];
            len_d     = len1;
          end else begin
            adv     = 1'b1;
            win_upd = 1'b1;
            z_val   = len1;
          end
        end else begin
          adv     = 1'b1;
          win_upd = 1'b1;
        end
      end
      S_EMIT: begin
        z_re       = 1'b1;
        z_raddr    = e_q;
        out_vld_d  = 1'b1;
        out_pos_d  = e_q;
        out_last_d = (CW'(e_q) + CW'(1) == n_q);
        out_ovf_d  = drop_q;
        if (out_last_d) begin
          cnt_d   = '0;
          drop_d  = 1'b0;
          state_d = S_IDLE;
        end else begin
          e_d = e_q + AW'(1);
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (adv) begin
      z_we    = 1'b1;
      z_waddr = k_q;
      z_wdata = z_val;
      if (win_upd) begin
        wl_d = k_q;
        wr_d = k_ext + z_val;
      end
      k_d     = k_next[AW-1:0];
      e_d     = '0;
      state_d = (k_next == n_q) ? S_EMIT : S_CHECK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      cnt_q      <= '0;
      drop_q     <= 1'b0;
      n_q        <= '0;
      k_q        <= '0;
      len_q      <= '0;
      wl_q       <= '0;
      wr_q       <= '0;
      e_q        <= '0;
      out_vld_q  <= 1'b0;
      out_pos_q  <= '0;
      out_last_q <= 1'b0;
      out_ovf_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      cnt_q      <= cnt_d;
      drop_q     <= drop_d;
      n_q        <= n_d;
      k_q        <= k_d;
      len_q      <= len_d;
      wl_q       <= wl_d;
      wr_q       <= wr_d;
      e_q        <= e_d;
      out_vld_q  <= out_vld_d;
      out_pos_q  <= out_pos_d;
      out_last_q <= out_last_d;
      out_ovf_q  <= out_ovf_d;
    end
  end

  zfe_char_mem #(
    .DEPTH (MAX_LEN),
    .AW    (AW)
  ) u_char_mem (
    .clk_i     (clk_i),
    .we_i      (c_we),
    .waddr_i   (c_waddr),
    .wdata_i   (in_i.char_in),
    .raddr_a_i (c_raddr_a),
    .raddr_b_i (c_raddr_b),
    .rdata_a_o (c_rdata_a),
    .rdata_b_o (c_rdata_b)
  );

  zfe_z_mem #(
    .DEPTH (MAX_LEN),
    .AW    (AW),
    .DW    (CW)
  ) u_z_mem (
    .clk_i   (clk_i),
    .we_i    (z_we),
    .waddr_i (z_waddr),
    .wdata_i (z_wdata),
    .re_i    (z_re),
    .raddr_i (z_raddr),
    .rdata_o (z_rdata)
  );

  assign busy                = (state_q != S_IDLE);
  assign res_strobe_o        = out_vld_q;
  assign res_o.position      = PosW'(out_pos_q);
  assign res_o.match_length  = LenW'(z_rdata);
  assign res_o.final_res     = out_last_q;
  assign res_o.overflow      = out_ovf_q;

endmodule
